>>> src/ali_pkg.sv
// ali_pkg: types, command codes and datapath functions for the AML integer ALU.
// Used by ali_front, ali_back and aml_integer_alu; depends on nothing.
package ali_pkg;

  localparam int DataWidth  = 32;
  localparam int CmdWidth   = 5;
  localparam int NumSteps   = DataWidth;          // one quotient / BCD bit per step
  localparam int StepIdxW   = $clog2(NumSteps);
  localparam int DdDigits   = 10;                 // 2^32 < 10^10
  localparam int AccWidth   = 4 * DdDigits;
  localparam int QueueDepth = 2;
  localparam int PosWidth   = $clog2(DataWidth) + 1;

  typedef logic [DataWidth-1:0] word_t;
  typedef logic [CmdWidth-1:0]  cmd_t;

  localparam cmd_t CmdAdd   = 5'd0;
  localparam cmd_t CmdSub   = 5'd1;
  localparam cmd_t CmdMul   = 5'd2;
  localparam cmd_t CmdAnd   = 5'd3;
  localparam cmd_t CmdNand  = 5'd4;
  localparam cmd_t CmdOr    = 5'd5;
  localparam cmd_t CmdNor   = 5'd6;
  localparam cmd_t CmdXor   = 5'd7;
  localparam cmd_t CmdShl   = 5'd8;
  localparam cmd_t CmdShr   = 5'd9;
  localparam cmd_t CmdLand  = 5'd10;
  localparam cmd_t CmdLnand = 5'd11;
  localparam cmd_t CmdLor   = 5'd12;
  localparam cmd_t CmdLnor  = 5'd13;
  localparam cmd_t CmdEq    = 5'd14;
  localparam cmd_t CmdNe    = 5'd15;
  localparam cmd_t CmdGt    = 5'd16;
  localparam cmd_t CmdLe    = 5'd17;
  localparam cmd_t CmdLt    = 5'd18;
  localparam cmd_t CmdGe    = 5'd19;
  localparam cmd_t CmdNot   = 5'd20;
  localparam cmd_t CmdInc   = 5'd21;
  localparam cmd_t CmdDec   = 5'd22;
  localparam cmd_t CmdLnot  = 5'd23;
  localparam cmd_t CmdLnz   = 5'd24;
  localparam cmd_t CmdDiv   = 5'd25;
  localparam cmd_t CmdFindL = 5'd26;
  localparam cmd_t CmdFindR = 5'd27;
  localparam cmd_t CmdFrBcd = 5'd28;
  localparam cmd_t CmdToBcd = 5'd29;

  typedef enum logic [1:0] {
    KindAlu   = 2'd0,
    KindDiv   = 2'd1,
    KindToBcd = 2'd2,
    KindFrBcd = 2'd3
  } kind_e;

  typedef struct packed {
    cmd_t  cmd;
    kind_e kind;
    word_t a;
    word_t b;
  } req_t;

  typedef struct packed {
    kind_e                kind;
    logic                 divz;
    word_t                res;
    word_t                rem;
    word_t                sh;    // dividend/quotient or source shifter
    word_t                dvs;
    logic [AccWidth-1:0]  acc;
  } work_t;

  function automatic kind_e classify(cmd_t cmd);
    kind_e k;
    case (cmd)
      CmdDiv:   k = KindDiv;
      CmdToBcd: k = KindToBcd;
      CmdFrBcd: k = KindFrBcd;
      default:  k = KindAlu;
    endcase
    return k;
  endfunction

  function automatic word_t truth(logic c);
    return c ? '1 : '0;
  endfunction

  // 1-based position of the lowest set bit, 0 if none
  function automatic word_t find_low(word_t v);
    word_t               iso;
    logic [PosWidth-1:0] p;
    iso = v & (~v + 1'b1);
    p   = '0;
    for (int i = 0; i < DataWidth; i++) begin
      p |= iso[i] ? PosWidth'(i + 1) : '0;
    end
    return word_t'(p);
  endfunction

  // 1-based position of the highest set bit, 0 if none
  function automatic word_t find_high(word_t v);
    word_t               rv;
    word_t               iso;
    logic [PosWidth-1:0] p;
    for (int i = 0; i < DataWidth; i++) begin
      rv[i] = v[DataWidth-1-i];
    end
    iso = rv & (~rv + 1'b1);
    p   = '0;
    for (int i = 0; i < DataWidth; i++) begin
      p |= iso[i] ? PosWidth'(DataWidth - i) : '0;
    end
    return word_t'(p);
  endfunction

  // combinational operations; iterative ones are finished in the step chain
  function automatic word_t alu_op(cmd_t cmd, word_t a, word_t b);
    word_t r;
    logic  big;
    big = (b >= word_t'(DataWidth));
    case (cmd)
      CmdAdd:   r = a + b;
      CmdSub:   r = a - b;
      CmdMul:   r = a * b;
      CmdAnd:   r = a & b;
      CmdNand:  r = ~(a & b);
      CmdOr:    r = a | b;
      CmdNor:   r = ~(a | b);
      CmdXor:   r = a ^ b;
      CmdShl:   r = big ? '0 : (a << b[StepIdxW-1:0]);
      CmdShr:   r = big ? '0 : (a >> b[StepIdxW-1:0]);
      CmdLand:  r = truth((a != '0) && (b != '0));
      CmdLnand: r = truth(!((a != '0) && (b != '0)));
      CmdLor:   r = truth((a != '0) || (b != '0));
      CmdLnor:  r = truth(!((a != '0) || (b != '0)));
      CmdEq:    r = truth(a == b);
      CmdNe:    r = truth(a != b);
      CmdGt:    r = truth(a > b);
      CmdLe:    r = truth(a <= b);
      CmdLt:    r = truth(a < b);
      CmdGe:    r = truth(a >= b);
      CmdNot:   r = ~a;
      CmdInc:   r = a + 1'b1;
      CmdDec:   r = a - 1'b1;
      CmdLnot:  r = truth(a == '0);
      CmdLnz:   r = truth(a != '0);
      CmdFindL: r = find_high(a);
      CmdFindR: r = find_low(a);
      default:  r = '0;
    endcase
    return r;
  endfunction

  // step: restoring divide bit, double-dabble bit, or BCD Horner digit on idx%4==0
  function automatic work_t step(work_t w, logic [StepIdxW-1:0] idx);
    work_t                n;
    logic [DataWidth:0]   trial;
    logic [DataWidth:0]   diff;
    logic [AccWidth-1:0]  adj;
    n = w;
    case (w.kind)
      KindDiv: begin
        trial = {w.rem, w.sh[DataWidth-1]};
        diff  = trial - {1'b0, w.dvs};
        if (!diff[DataWidth]) begin
          n.rem = diff[DataWidth-1:0];
          n.sh  = {w.sh[DataWidth-2:0], 1'b1};
        end else begin
          n.rem = trial[DataWidth-1:0];
          n.sh  = {w.sh[DataWidth-2:0], 1'b0};
        end
      end
      KindToBcd: begin
        for (int d = 0; d < DdDigits; d++) begin
          adj[4*d +: 4] = (w.acc[4*d +: 4] >= 4'd5) ? w.acc[4*d +: 4] + 4'd3
                                                     : w.acc[4*d +: 4];
        end
        n.acc = {adj[AccWidth-2:0], w.sh[DataWidth-1]};
        n.sh  = w.sh << 1;
      end
      KindFrBcd: begin
        if (idx[1:0] == 2'd0) begin
          n.acc = (w.acc << 3) + (w.acc << 1) + AccWidth'(w.sh[DataWidth-1 -: 4]);
          n.sh  = w.sh << 4;
        end
      end
      default: begin
      end
    endcase
    return n;
  endfunction

endpackage

>>> src/ali_front.sv
// ali_front: accepts requests, classifies the command and holds them in a
// two-entry queue for the back end. Depends on ali_pkg.
module ali_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ali_pkg::cmd_t    command_i,
  input  ali_pkg::word_t   operand_a_i,
  input  ali_pkg::word_t   operand_b_i,
  output logic             req_valid_o,
  input  logic             req_ready_i,
  output ali_pkg::req_t    req_o
);

  ali_pkg::req_t mem_q [ali_pkg::QueueDepth];
  logic          wr_q, wr_d, rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign in_ready_o  = (cnt_q != 2'(ali_pkg::QueueDepth));
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop  ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{cmd:  command_i,
                       kind: ali_pkg::classify(command_i),
                       a:    operand_a_i,
                       b:    operand_b_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(ali_pkg::QueueDepth))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wr_q == rd_q))
    else $error("empty queue with split pointers");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(ali_pkg::QueueDepth)) |-> (wr_q == rd_q))
    else $error("full queue with split pointers");

endmodule

>>> src/ali_back.sv
// ali_back: executes queued requests in a pipeline of step stages with an
// output register. Depends on ali_pkg.
module ali_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  ali_pkg::req_t    req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ali_pkg::word_t   result_o,
  output ali_pkg::word_t   remainder_o,
  output logic             error_o
);

  localparam int N = ali_pkg::NumSteps;

  ali_pkg::work_t stg_q [N+1];
  ali_pkg::work_t stg_d [N+1];
  logic [N:0]     vld_q;
  logic           out_vld_q;
  ali_pkg::kind_e out_kind_q;
  ali_pkg::word_t res_q, rem_q, res_d, rem_d;
  logic           err_q;
  logic           en;

  // whole chain advances whenever the output register can take a result
  assign en          = !out_vld_q || out_ready_i;
  assign req_ready_o = en;

  always_comb begin
    stg_d[0].kind = req_i.kind;
    stg_d[0].divz = (req_i.b == '0);
    stg_d[0].res  = ali_pkg::alu_op(req_i.cmd, req_i.a, req_i.b);
    stg_d[0].rem  = '0;
    stg_d[0].sh   = req_i.a;
    stg_d[0].dvs  = req_i.b;
    stg_d[0].acc  = '0;
    for (int i = 0; i < N; i++) begin
      stg_d[i+1] = ali_pkg::step(stg_q[i], ali_pkg::StepIdxW'(i));
    end
  end

  always_comb begin
    res_d = stg_q[N].res;
    rem_d = '0;
    case (stg_q[N].kind)
      ali_pkg::KindDiv: begin
        res_d = stg_q[N].divz ? '0 : stg_q[N].sh;
        rem_d = stg_q[N].divz ? '0 : stg_q[N].rem;
      end
      ali_pkg::KindToBcd: res_d = stg_q[N].acc[ali_pkg::DataWidth-1:0];
      ali_pkg::KindFrBcd: res_d = stg_q[N].acc[ali_pkg::DataWidth-1:0];
      default:            res_d = stg_q[N].res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[N-1:0], req_valid_i};
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i <= N; i++) begin
        stg_q[i] <= stg_d[i];
      end
      res_q      <= res_d;
      rem_q      <= rem_d;
      err_q      <= (stg_q[N].kind == ali_pkg::KindDiv) && stg_q[N].divz;
      out_kind_q <= stg_q[N].kind;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;
  assign remainder_o = rem_q;
  assign error_o     = err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && err_q) |-> (res_q == '0 && rem_q == '0))
    else $error("divide error with nonzero data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q != ali_pkg::KindDiv) |-> (rem_q == '0 && !err_q))
    else $error("remainder or error on non-divide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en) |=> ($stable(vld_q) && out_vld_q))
    else $error("pipeline moved while stalled");

endmodule

>>> src/aml_integer_alu.sv
// aml_integer_alu: top level of the AML 32-bit integer ALU.
// Instantiates ali_front and ali_back; depends on ali_pkg.

// One request carries a command and two 32-bit operands and produces exactly
// one result (result, remainder, error). Requests enter at one per cycle while
// the queue has room and results leave in request order; each request passes
// from accept to output valid through the queue slot, the decode/ALU stage,
// the 32-stage step chain that forms one quotient bit (restoring divide) or
// one double-dabble bit per stage, and the output register. Every command
// runs through the same chain, so ordering needs no tracking. A two-entry
// queue in the front end feeds the chain; a stalled output freezes the chain,
// the queue keeps taking requests until it fills. Divide by zero returns
// zero data with error set; unused commands return zeros.
module aml_integer_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ali_pkg::cmd_t    command_i,
  input  ali_pkg::word_t   operand_a_i,
  input  ali_pkg::word_t   operand_b_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ali_pkg::word_t   result_o,
  output ali_pkg::word_t   remainder_o,
  output logic             error_o
);

  ali_pkg::req_t req;
  logic          req_valid, req_ready;

  // front end: accept and classify
  ali_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  // back end: execute and deliver
  ali_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o),
    .remainder_o (remainder_o),
    .error_o     (error_o)
  );

endmodule

>>> tb/tb.sv
// tb: self-checking testbench for aml_integer_alu, the AML 32-bit integer ALU.
// Depends on ali_pkg for command codes and word types; predicts each result
// in-line and compares it against the DUT output in request order.
module tb;

  typedef struct {
    ali_pkg::cmd_t  cmd;
    ali_pkg::word_t a;
    ali_pkg::word_t b;
  } alu_req_t;

  typedef struct {
    ali_pkg::word_t res;
    ali_pkg::word_t rem;
    logic           err;
  } alu_res_t;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  ali_pkg::cmd_t  command_i;
  ali_pkg::word_t operand_a_i;
  ali_pkg::word_t operand_b_i;
  logic           out_valid_o;
  logic           out_ready_i;
  ali_pkg::word_t result_o;
  ali_pkg::word_t remainder_o;
  logic           error_o;

  alu_req_t pending_q[$];
  alu_res_t expected_q[$];
  int       n_errors;
  int       n_checked;
  int       n_div_zero;
  int       cycle_cnt;
  bit       in_taken;

  aml_integer_alu u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o),
    .remainder_o (remainder_o),
    .error_o     (error_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Golden ALU: computes the expected result for one request.
  function automatic alu_res_t alu_predict(alu_req_t r);
    alu_res_t o;
    logic [63:0] v;
    logic [63:0] acc;
    logic [63:0] wt;
    o.res = '0;
    o.rem = '0;
    o.err = 1'b0;
    case (r.cmd)
      ali_pkg::CmdAdd:   o.res = r.a + r.b;
      ali_pkg::CmdSub:   o.res = r.a - r.b;
      ali_pkg::CmdMul:   o.res = r.a * r.b;
      ali_pkg::CmdAnd:   o.res = r.a & r.b;
      ali_pkg::CmdNand:  o.res = ~(r.a & r.b);
      ali_pkg::CmdOr:    o.res = r.a | r.b;
      ali_pkg::CmdNor:   o.res = ~(r.a | r.b);
      ali_pkg::CmdXor:   o.res = r.a ^ r.b;
      ali_pkg::CmdShl:   o.res = (r.b >= 32) ? '0 : r.a << r.b;
      ali_pkg::CmdShr:   o.res = (r.b >= 32) ? '0 : r.a >> r.b;
      ali_pkg::CmdLand:  o.res = {32{(r.a != 0) && (r.b != 0)}};
      ali_pkg::CmdLnand: o.res = {32{!((r.a != 0) && (r.b != 0))}};
      ali_pkg::CmdLor:   o.res = {32{(r.a != 0) || (r.b != 0)}};
      ali_pkg::CmdLnor:  o.res = {32{!((r.a != 0) || (r.b != 0))}};
      ali_pkg::CmdEq:    o.res = {32{r.a == r.b}};
      ali_pkg::CmdNe:    o.res = {32{r.a != r.b}};
      ali_pkg::CmdGt:    o.res = {32{r.a > r.b}};
      ali_pkg::CmdLe:    o.res = {32{r.a <= r.b}};
      ali_pkg::CmdLt:    o.res = {32{r.a < r.b}};
      ali_pkg::CmdGe:    o.res = {32{r.a >= r.b}};
      ali_pkg::CmdNot:   o.res = ~r.a;
      ali_pkg::CmdInc:   o.res = r.a + 32'd1;
      ali_pkg::CmdDec:   o.res = r.a - 32'd1;
      ali_pkg::CmdLnot:  o.res = {32{r.a == 0}};
      ali_pkg::CmdLnz:   o.res = {32{r.a != 0}};
      ali_pkg::CmdDiv: begin
        if (r.b == 0) begin
          o.err = 1'b1;
        end else begin
          o.res = r.a / r.b;
          o.rem = r.a % r.b;
        end
      end
      ali_pkg::CmdFindL: begin
        for (int i = 0; i < 32; i++) begin
          if (r.a[i]) o.res = ali_pkg::word_t'(i + 1);
        end
      end
      ali_pkg::CmdFindR: begin
        for (int i = 31; i >= 0; i--) begin
          if (r.a[i]) o.res = ali_pkg::word_t'(i + 1);
        end
      end
      ali_pkg::CmdFrBcd: begin
        // nibbles above 9 still weigh in at their raw value
        acc = 0;
        wt  = 1;
        for (int i = 0; i < 8; i++) begin
          acc = acc + r.a[4*i +: 4] * wt;
          wt  = wt * 10;
        end
        o.res = acc[31:0];
      end
      ali_pkg::CmdToBcd: begin
        // keep only the 8 low decimal digits
        v = r.a;
        for (int i = 0; i < 8; i++) begin
          o.res[4*i +: 4] = 4'(v % 10);
          v = v / 10;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, ali_pkg::word_t got, ali_pkg::word_t want);
    $display("MISMATCH %s at cycle %0d: got %h expected %h", what, cycle_cnt, got, want);
    n_errors++;
  endtask

  function automatic ali_pkg::word_t rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 40);
      3: return 32'h8000_0000 >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_req(ali_pkg::cmd_t c, ali_pkg::word_t a, ali_pkg::word_t b);
    alu_req_t r;
    r.cmd = c;
    r.a   = a;
    r.b   = b;
    pending_q.push_back(r);
  endtask

  // Idle about 6 percent of the time, none during the quiet window.
  function automatic bit idle_now();
    if (cycle_cnt > 800 && cycle_cnt < 1300) return 1'b0;
    return $urandom_range(0, 99) < 6;
  endfunction

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Driver: request side and out_ready_i, changes at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      // in_taken holds the handshake seen at the last rising edge
      if (pending_q.size() > 0 && !idle_now()) begin
        in_valid_i  <= 1'b1;
        command_i   <= pending_q[0].cmd;
        operand_a_i <= pending_q[0].a;
        operand_b_i <= pending_q[0].b;
        void'(pending_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= !idle_now();
  end

  // Accept on the rising edge: predict on request handshake.
  always @(posedge clk_i) begin
    alu_req_t r;
    alu_res_t e;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      r.cmd = command_i;
      r.a   = operand_a_i;
      r.b   = operand_b_i;
      expected_q.push_back(alu_predict(r));
    end
    // Monitor: compare each returned result with the oldest prediction.
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", result_o, '0);
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.err) n_div_zero++;
        if (result_o !== e.res) report_mismatch("result", result_o, e.res);
        if (remainder_o !== e.rem) report_mismatch("remainder", remainder_o, e.rem);
        if (error_o !== e.err) begin
          report_mismatch("error", ali_pkg::word_t'(error_o), ali_pkg::word_t'(e.err));
        end
      end
    end
  end

  initial begin
    ali_pkg::cmd_t c;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    command_i   = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    n_errors    = 0;
    n_checked   = 0;
    n_div_zero  = 0;
    cycle_cnt   = 0;
    in_taken    = 1'b0;

    // directed: extremes, every command, special cases
    push_req(ali_pkg::CmdAdd, '1, 32'd1);
    push_req(ali_pkg::CmdSub, '0, 32'd1);
    push_req(ali_pkg::CmdMul, '1, '1);
    push_req(ali_pkg::CmdShl, 32'h1, 32'd31);
    push_req(ali_pkg::CmdShl, '1, 32'd32);
    push_req(ali_pkg::CmdShr, '1, '1);
    push_req(ali_pkg::CmdDiv, 32'd100, '0);           // divide by zero
    push_req(ali_pkg::CmdDiv, '1, 32'd7);
    push_req(ali_pkg::CmdFindL, '0, '0);              // no set bit
    push_req(ali_pkg::CmdFindL, 32'h8000_0000, '0);
    push_req(ali_pkg::CmdFindR, 32'h8000_0000, '1);
    push_req(ali_pkg::CmdFrBcd, 32'hFFFF_FFFF, '0);   // non-decimal nibbles
    push_req(ali_pkg::CmdToBcd, '1, '0);              // value wider than 8 digits
    push_req(ali_pkg::CmdToBcd, 32'd99999999, '0);
    push_req(5'd30, '1, '1);                          // unused commands
    push_req(5'd31, '1, '1);
    for (int i = 0; i < 30; i++) begin
      c = ali_pkg::cmd_t'(i);
      push_req(c, $urandom(), $urandom());
    end
    for (int i = 0; i < 2000; i++) begin
      c = ($urandom_range(0, 9) == 0) ? ali_pkg::cmd_t'($urandom_range(0, 31))
                                      : ali_pkg::cmd_t'($urandom_range(0, 29));
      push_req(c, rand_word(), rand_word());
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk_i);

    $display("Checked %0d results across all 32 command codes, %0d divides by zero.",
             n_checked, n_div_zero);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timeout at cycle %0d", cycle_cnt);
    $display("Verification failed");
    $finish;
  end

endmodule
